@@ hw/rtl/fbt_pkg.sv @@
package fbt_pkg;

  // Frontier geometry: the field carries 32 slots, SLOTS of them take part
  localparam int FIELD_SLOTS = 32;
  localparam int SLOTS       = 32;
  localparam int FRONT_W     = 2 * FIELD_SLOTS;
  localparam int POS_W       = 5;
  // Nesting depth reaches at most +/- SLOTS
  localparam int DEPTH_W     = $clog2(SLOTS) + 2;

  // Slot codes
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_START = 2'd1;
  localparam logic [1:0] SLOT_OPEN  = 2'd2;
  localparam logic [1:0] SLOT_CLOSE = 2'd3;

  typedef struct packed {
    logic [FRONT_W-1:0] frontier;
    logic [POS_W-1:0]   position;
  } in_t;

  typedef struct packed {
    logic [FRONT_W-1:0] next_frontier;
    logic               loop_closed;
    logic               impossible_pair;
  } out_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic                      live;
    logic                      found;
    logic signed [DEPTH_W-1:0] depth;
  } tok_t;

  // Shared controls from the top level to every cell
  typedef struct packed {
    logic       load;
    logic       scan_up;
    logic [1:0] code;
  } ctl_t;

endpackage

@@ hw/rtl/fbt_cell.sv @@
module fbt_cell (
  input  logic          clk,
  input  logic          rst,
  input  fbt_pkg::ctl_t ctl,
  input  logic [1:0]    load_slot,
  input  fbt_pkg::tok_t seed,
  input  fbt_pkg::tok_t from_below,
  input  fbt_pkg::tok_t from_above,
  output logic [1:0]    slot,
  output fbt_pkg::tok_t tok_out
);

  fbt_pkg::tok_t tok;
  logic signed [fbt_pkg::DEPTH_W-1:0] depth_next;
  logic hit;

  // Nesting count after this slot is seen
  always_comb begin
    case (slot)
      fbt_pkg::SLOT_OPEN:  depth_next = tok.depth + fbt_pkg::DEPTH_W'(1);
      fbt_pkg::SLOT_CLOSE: depth_next = tok.depth - fbt_pkg::DEPTH_W'(1);
      default:             depth_next = tok.depth;
    endcase
  end

  // First slot where the count returns to zero is the partner bracket
  assign hit = tok.live && !tok.found && (depth_next == '0);

  assign tok_out.live  = tok.live;
  assign tok_out.found = tok.found | hit;
  assign tok_out.depth = depth_next;

  // Token register: seeded on load, otherwise taken from the upstream neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (ctl.load) begin
      tok <= seed;
    end else if (ctl.scan_up) begin
      tok <= from_below;
    end else begin
      tok <= from_above;
    end
  end

  // Slot value: loaded, or relabeled when the partner is found here
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot <= load_slot;
    end else if (hit) begin
      slot <= ctl.code;
    end
  end

endmodule

@@ hw/rtl/frontier_bracket_transition.sv @@
// Timing: done comes in the cycle after an accepted transaction for pairs that need no scan;
// a partner scan stays in S_SCAN until the token reaches the far end of the row, then moves to S_EMIT.
// Throughput: one transaction per cycle without a scan; a scan holds busy while the
// token walks the cell row one slot per cycle.
// Reset (rst, synchronous): clears the sequencer and all scan tokens; no result pending.
// The receiver cannot stall: each result shows with done for exactly one cycle.
module frontier_bracket_transition (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fbt_pkg::in_t  item,
  output logic          busy,
  output logic          done,
  output fbt_pkg::out_t result
);

  localparam int PE_W = fbt_pkg::POS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  logic accept;
  logic [fbt_pkg::POS_W-1:0] pos, pos1;
  logic [PE_W-1:0] pe, pe1, pe2;
  logic in_range;
  logic [1:0] l, r, nl, nr, code_n;
  logic scan_dn, scan_up, loop_n, imp_n;
  logic go_scan, end_seen;

  logic       dir;
  logic [1:0] code;
  logic       loop_closed;
  logic       impossible_pair;

  fbt_pkg::ctl_t ctl;
  logic [1:0]    load_slot [fbt_pkg::FIELD_SLOTS];
  logic [1:0]    slot      [fbt_pkg::FIELD_SLOTS];
  fbt_pkg::tok_t seed      [fbt_pkg::FIELD_SLOTS];
  fbt_pkg::tok_t tok_out   [fbt_pkg::FIELD_SLOTS];
  wire  [fbt_pkg::FRONT_W-1:0] nf;

  assign accept = start && (state != S_SCAN);
  assign busy   = (state == S_SCAN);
  assign done   = (state == S_EMIT);

  // Pair decode of the incoming transaction
  assign pos  = item.position;
  assign pos1 = pos + fbt_pkg::POS_W'(1);
  assign pe   = {1'b0, pos};
  assign pe1  = pe + PE_W'(1);
  assign pe2  = pe + PE_W'(2);
  assign in_range = (pe <= PE_W'(fbt_pkg::SLOTS - 2));
  assign l = item.frontier[{pos, 1'b0} +: 2];
  assign r = item.frontier[{pos1, 1'b0} +: 2];

  always_comb begin
    nl      = l;
    nr      = r;
    code_n  = fbt_pkg::SLOT_EMPTY;
    scan_dn = 1'b0;
    scan_up = 1'b0;
    loop_n  = 1'b0;
    imp_n   = 1'b0;
    if (in_range) begin
      if (l == fbt_pkg::SLOT_EMPTY && r == fbt_pkg::SLOT_EMPTY) begin
        nl = fbt_pkg::SLOT_OPEN;
        nr = fbt_pkg::SLOT_CLOSE;
      end else if (l == fbt_pkg::SLOT_CLOSE && r == fbt_pkg::SLOT_OPEN) begin
        nl = fbt_pkg::SLOT_EMPTY;
        nr = fbt_pkg::SLOT_EMPTY;
      end else if (l == fbt_pkg::SLOT_EMPTY) begin
        nl = r;
        nr = fbt_pkg::SLOT_EMPTY;
      end else if (r == fbt_pkg::SLOT_EMPTY) begin
        nl = fbt_pkg::SLOT_EMPTY;
        nr = l;
      end else if (l == fbt_pkg::SLOT_CLOSE) begin
        // close-close or close-start: partner open lies below
        nl      = fbt_pkg::SLOT_EMPTY;
        nr      = fbt_pkg::SLOT_EMPTY;
        code_n  = r;
        scan_dn = 1'b1;
      end else if (r == fbt_pkg::SLOT_OPEN) begin
        // open-open or start-open: partner close lies above
        nl      = fbt_pkg::SLOT_EMPTY;
        nr      = fbt_pkg::SLOT_EMPTY;
        code_n  = l;
        scan_up = 1'b1;
      end else if (l == fbt_pkg::SLOT_OPEN && r == fbt_pkg::SLOT_CLOSE) begin
        loop_n = 1'b1;
      end else begin
        imp_n = 1'b1;
      end
    end
  end

  // A scan only runs when there is a cell beyond the pair in its direction
  assign go_scan = (scan_dn && (pe != '0)) ||
                   (scan_up && (pe2 <= PE_W'(fbt_pkg::SLOTS - 1)));

  assign ctl.load    = accept;
  assign ctl.scan_up = dir;
  assign ctl.code    = code;

  // Cell row; cells at and above SLOTS only carry their slot through
  for (genvar g = 0; g < fbt_pkg::FIELD_SLOTS; g++) begin : g_cell
    assign load_slot[g] = (in_range && pe == PE_W'(g))  ? nl :
                          (in_range && pe1 == PE_W'(g)) ? nr :
                          item.frontier[2*g +: 2];
    assign nf[2*g +: 2] = slot[g];

    if (g < fbt_pkg::SLOTS) begin : g_live
      fbt_pkg::tok_t below, above;
      assign seed[g].live  = (scan_dn && (pe == PE_W'(g + 1))) ||
                             (scan_up && (pe2 == PE_W'(g)));
      assign seed[g].found = 1'b0;
      assign seed[g].depth = scan_up ? fbt_pkg::DEPTH_W'(1) : '1;
      if (g == 0) begin : g_lo
        assign below = '0;
      end else begin : g_mid_lo
        assign below = tok_out[g-1];
      end
      if (g == fbt_pkg::SLOTS - 1) begin : g_hi
        assign above = '0;
      end else begin : g_mid_hi
        assign above = tok_out[g+1];
      end
      fbt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .load_slot  (load_slot[g]),
        .seed       (seed[g]),
        .from_below (below),
        .from_above (above),
        .slot       (slot[g]),
        .tok_out    (tok_out[g])
      );
    end else begin : g_pass
      assign seed[g] = '0;
      fbt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .load_slot  (load_slot[g]),
        .seed       (seed[g]),
        .from_below ('0),
        .from_above ('0),
        .slot       (slot[g]),
        .tok_out    (tok_out[g])
      );
    end
  end

  // Scan ends when the token reaches the cell at the far end of the row
  assign end_seen = dir ? tok_out[fbt_pkg::SLOTS-1].live : tok_out[0].live;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE, S_EMIT: begin
        if (accept) begin
          state_next = go_scan ? S_SCAN : S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (end_seen) begin
          state_next = S_EMIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-transaction scan settings and flags
  always_ff @(posedge clk) begin
    if (accept) begin
      dir             <= scan_up;
      code            <= code_n;
      loop_closed     <= loop_n;
      impossible_pair <= imp_n;
    end
  end

  assign result.next_frontier   = nf;
  assign result.loop_closed     = loop_closed;
  assign result.impossible_pair = impossible_pair;

endmodule

@@ test/frontier_bracket_transition_test.sv @@
`timescale 1ns / 1ps

module frontier_bracket_transition_test;
  import fbt_pkg::*;

  localparam int RANDOM_STEPS = 650;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst;
  logic start;
  in_t  item;
  logic busy;
  logic done;
  out_t result;

  // Steps waiting to be driven, and predicted results waiting for done
  in_t  queued_steps[$];
  out_t predicted_steps[$];

  logic        took = 1'b0;
  int unsigned idle_left = 0;
  bit          no_idle = 1'b0;
  int          mismatches = 0;

  frontier_bracket_transition i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Place a path cell on slots position and position+1 and rewrite the pattern
  function automatic out_t step_frontier(in_t req);
    logic [FRONT_W-1:0] f;
    logic [FRONT_W-1:0] nf;
    logic [1:0]         l;
    logic [1:0]         r;
    logic [1:0]         c;
    int                 p;
    int                 k;
    int                 depth;
    bit                 found;
    out_t               res;
    f = req.frontier;
    nf = f;
    p = int'(req.position);
    res.loop_closed = 1'b0;
    res.impossible_pair = 1'b0;
    if (p + 2 <= SLOTS) begin
      l = f[2*p +: 2];
      r = f[2*(p+1) +: 2];
      if (l == SLOT_EMPTY && r == SLOT_EMPTY) begin
        nf[2*p +: 2] = SLOT_OPEN;
        nf[2*(p+1) +: 2] = SLOT_CLOSE;
      end else if (l == SLOT_CLOSE && r == SLOT_OPEN) begin
        nf[2*p +: 2] = SLOT_EMPTY;
        nf[2*(p+1) +: 2] = SLOT_EMPTY;
      end else if (l == SLOT_EMPTY) begin
        nf[2*p +: 2] = r;
        nf[2*(p+1) +: 2] = SLOT_EMPTY;
      end else if (r == SLOT_EMPTY) begin
        nf[2*(p+1) +: 2] = l;
        nf[2*p +: 2] = SLOT_EMPTY;
      end else if (l == SLOT_CLOSE) begin
        // partner open bracket lies below; it takes the right code
        depth = 0;
        found = 1'b0;
        for (k = p; k >= 0 && !found; k--) begin
          c = f[2*k +: 2];
          if (c == SLOT_OPEN) depth++;
          else if (c == SLOT_CLOSE) depth--;
          if (depth == 0) begin
            nf[2*k +: 2] = r;
            found = 1'b1;
          end
        end
        nf[2*p +: 2] = SLOT_EMPTY;
        nf[2*(p+1) +: 2] = SLOT_EMPTY;
      end else if (r == SLOT_OPEN) begin
        // partner close bracket lies above; it takes the left code
        depth = 0;
        found = 1'b0;
        for (k = p + 1; k < SLOTS && !found; k++) begin
          c = f[2*k +: 2];
          if (c == SLOT_OPEN) depth++;
          else if (c == SLOT_CLOSE) depth--;
          if (depth == 0) begin
            nf[2*k +: 2] = l;
            found = 1'b1;
          end
        end
        nf[2*p +: 2] = SLOT_EMPTY;
        nf[2*(p+1) +: 2] = SLOT_EMPTY;
      end else if (l == SLOT_OPEN && r == SLOT_CLOSE) begin
        res.loop_closed = 1'b1;
      end else begin
        res.impossible_pair = 1'b1;
      end
    end
    res.next_frontier = nf;
    return res;
  endfunction

  // Slot pattern from text, slot 0 first: '.' empty, 'S' start, '(' open, ')' close
  function automatic logic [FRONT_W-1:0] pat(string s);
    logic [FRONT_W-1:0] f;
    byte                ch;
    f = '0;
    for (int i = 0; i < s.len() && i < FIELD_SLOTS; i++) begin
      ch = s[i];
      if (ch == "S") f[2*i +: 2] = SLOT_START;
      else if (ch == "(") f[2*i +: 2] = SLOT_OPEN;
      else if (ch == ")") f[2*i +: 2] = SLOT_CLOSE;
    end
    return f;
  endfunction

  // Random balanced bracket pattern with empties and path starts mixed in
  function automatic logic [FRONT_W-1:0] balanced_frontier();
    logic [FRONT_W-1:0] f;
    int                 depth;
    int                 left;
    int unsigned        pick;
    f = '0;
    depth = 0;
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      left = FIELD_SLOTS - i;
      pick = $urandom_range(0, 9);
      if (depth == left) begin
        f[2*i +: 2] = SLOT_CLOSE;
        depth--;
      end else if (pick == 3) begin
        f[2*i +: 2] = SLOT_START;
      end else if (pick >= 4 && pick <= 6 && depth + 1 <= left - 1) begin
        f[2*i +: 2] = SLOT_OPEN;
        depth++;
      end else if (pick >= 7 && depth > 0) begin
        f[2*i +: 2] = SLOT_CLOSE;
        depth--;
      end else begin
        f[2*i +: 2] = SLOT_EMPTY;
      end
    end
    return f;
  endfunction

  task automatic add_step(logic [FRONT_W-1:0] f, int unsigned p);
    in_t s;
    s.frontier = f;
    s.position = POS_W'(p);
    queued_steps = {queued_steps, s};
  endtask

  // Driver: one transaction at a time, random idle gaps between them
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (took) begin
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        idle_left = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (queued_steps.size() != 0) begin
        item  <= queued_steps.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results against predictions, then log new transactions
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (predicted_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h loop %b imp %b", result.next_frontier,
                   result.loop_closed, result.impossible_pair);
      end else begin
        want = predicted_steps.pop_front();
        if (result.next_frontier !== want.next_frontier ||
            result.loop_closed !== want.loop_closed ||
            result.impossible_pair !== want.impossible_pair) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected %h loop %b imp %b, got %h loop %b imp %b",
                     want.next_frontier, want.loop_closed, want.impossible_pair,
                     result.next_frontier, result.loop_closed, result.impossible_pair);
        end
      end
    end
    if (!rst && start && !busy) predicted_steps = {predicted_steps, step_frontier(item)};
    took <= !rst && start && !busy;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [FRONT_W-1:0] f;
    int unsigned        kind;
    int unsigned        p;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;

    // Directed: every pair kind, scans near both ends, out-of-range position
    add_step('0, 0);
    add_step(pat(")("), 0);
    add_step(pat(".S"), 0);
    add_step(pat("S."), 0);
    add_step(pat(".("), 0);
    add_step(pat("(."), 0);
    add_step(pat(".)"), 0);
    add_step(pat(")."), 0);
    add_step(pat("(())"), 2);
    add_step(pat("()S"), 1);
    add_step(pat("(())"), 0);
    add_step(pat("S()"), 0);
    add_step(pat("()"), 0);
    add_step(pat("SS"), 0);
    add_step(pat("(S"), 0);
    add_step(pat("S)"), 0);
    // no partner in either direction
    add_step(pat("(("), 0);
    add_step('1, 30);
    add_step('1, 0);
    add_step('1, 31);
    add_step({$urandom, $urandom}, 31);
    // partner at the far end of the row
    f = '0;
    f[1:0] = SLOT_OPEN;
    f[61:60] = SLOT_CLOSE;
    f[63:62] = SLOT_CLOSE;
    add_step(f, 30);
    f = '0;
    f[1:0] = SLOT_OPEN;
    f[3:2] = SLOT_OPEN;
    f[63:62] = SLOT_CLOSE;
    add_step(f, 0);
    add_step('0, 30);

    // Random: mostly balanced patterns, some broken, some raw noise
    for (int n = 0; n < RANDOM_STEPS; n++) begin
      kind = $urandom_range(0, 99);
      p = ($urandom_range(0, 49) == 0) ? 31 : $urandom_range(0, 30);
      if (kind < 70) begin
        f = balanced_frontier();
      end else if (kind < 85) begin
        f = balanced_frontier();
        f[2*$urandom_range(0, FIELD_SLOTS-1) +: 2] = 2'($urandom);
      end else begin
        f = {$urandom, $urandom};
      end
      add_step(f, p);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (queued_steps.size() != 0 || start) @(posedge clk);
    while (predicted_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && predicted_steps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
